[hw/rtl/mhkv_pkg.sv]
// ----------------------------------------------------------------------------
// mhkv_pkg: shared types and constants for the multi-hash key/value cache
// Transfer payloads, operation and status codes, sequencer states and the
// ring-position staleness test.
// ----------------------------------------------------------------------------
package mhkv_pkg;

   localparam int INDEX_BITS_DEF = 12;
   localparam int CACHE_BITS_DEF = 10;
   localparam int MAX_CHAIN_DEF  = 9;

   localparam int KEY_WORDS   = 4;
   localparam int VALUE_WORDS = 12;
   localparam int SHORT_WORDS = 8;

   typedef enum logic [1:0] {
      OP_STAGE  = 2'd0,
      OP_FIND   = 2'd1,
      OP_ADD    = 2'd2,
      OP_UPDATE = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_HIT     = 3'd0,
      ST_MISS    = 3'd1,
      ST_NEW     = 3'd2,
      ST_UPDATED = 3'd3,
      ST_KEPT    = 3'd4,
      ST_FORCED  = 3'd5,
      ST_FAILED  = 3'd6,
      ST_STAGED  = 3'd7
   } status_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_PR_RD,
      S_PR_CHK,
      S_KC_RD,
      S_KC_CHK,
      S_WR,
      S_FD_RD,
      S_FD_OUT,
      S_CH_STEP,
      S_CH_KRD,
      S_CH_IRD,
      S_CH_CHK,
      S_CH_END,
      S_REPLY
   } state_type;

   // what follows a finished entry write
   typedef enum logic [1:0] {
      AW_NEW,
      AW_UPD,
      AW_CHAIN
   } after_type;

   typedef struct packed {
      logic [1:0]  operation;
      logic [63:0] key_word_0;
      logic [63:0] key_word_1;
      logic [63:0] key_word_2;
      logic [63:0] key_word_3;
      logic [3:0]  value_slot;
      logic [63:0] value_word;
      logic        leaf_entry;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [3:0]  word_slot;
      logic [63:0] data_word;
      logic        last;
   } rsp_type;

   // pick one key word by its position
   function automatic logic [63:0] key_word(req_type r, logic [1:0] sel);
      logic [63:0] w;
      unique case (sel)
         2'd0: w = r.key_word_0;
         2'd1: w = r.key_word_1;
         2'd2: w = r.key_word_2;
         default: w = r.key_word_3;
      endcase
      return w;
   endfunction

   // a raw position is stale when it trails the pointer by more than size
   function automatic logic is_stale(logic [31:0] cur, logic [31:0] raw,
                                     logic [31:0] size);
      logic [31:0] d;
      d = (cur >= raw) ? (cur - raw) : (cur - raw - 32'd1);
      return d > size;
   endfunction

endpackage

[hw/rtl/mhkv_ram.sv]
// ----------------------------------------------------------------------------
// mhkv_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module mhkv_ram #(
   parameter int          WIDTH  = 64,
   parameter int          ADDR_W = 10,
   parameter longint      DEPTH  = 1024
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [0:DEPTH-1];
   logic [WIDTH-1:0] rd_data_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/multi_hash_key_value_cache.sv]
// ----------------------------------------------------------------------------
// multi_hash_key_value_cache: four-way multi-hash key/value cache
// Maps a four-word key to a twelve-word value through a ring of cache entries
// and an index table probed by each key word, with displacement on overflow.
// ----------------------------------------------------------------------------
// Usage: requests arrive on req_valid/req_stall/req_payload; results leave on
// rsp_valid/rsp_stall/rsp_payload. A stage request answers one staged result;
// a find answers twelve hit words (last on word 11) or one miss; an add
// answers one status. One request is worked at a time by a sequencer over the
// index, key and value RAMs, each with one read port with registered data.
// Each live index probe is followed by a key compare; a find hit then reads
// the value words in turn; an entry write stores the value and key words in
// turn; each displacement step reads every key word of the entry and its
// index slot (at most MAX_CHAIN steps).
// Reset clears the sequencer and pointer, then runs a clearing pass over
// the index table; req_stall stays high meanwhile.
// The result register holds while rsp_stall is high; a new request is taken
// as soon as the previous result is loaded, even if not yet transferred.
// ----------------------------------------------------------------------------
module multi_hash_key_value_cache #(
   parameter int INDEX_BITS = mhkv_pkg::INDEX_BITS_DEF,
   parameter int CACHE_BITS = mhkv_pkg::CACHE_BITS_DEF,
   parameter int MAX_CHAIN  = mhkv_pkg::MAX_CHAIN_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  mhkv_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output mhkv_pkg::rsp_type rsp_payload
);

   localparam logic [31:0] CACHE_SIZE = 32'(64'd1 << CACHE_BITS);
   localparam logic [31:0] IDX_RESET  = 32'hFFFF_FFFF - CACHE_SIZE - 32'd1;
   localparam int KA_W = CACHE_BITS + 2;
   localparam int VA_W = CACHE_BITS + 4;
   localparam int UW   = $clog2(MAX_CHAIN + 1);
   localparam int CH_N = MAX_CHAIN + 1;

   mhkv_pkg::state_type  state_ff, state_in;
   mhkv_pkg::req_type    req_ff, req_in;
   mhkv_pkg::rsp_type    rsp_ff, rsp_in;
   mhkv_pkg::status_type status_ff, status_in;
   mhkv_pkg::after_type  after_ff, after_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [1:0]           i_ff, i_in, j_ff, j_in;
   logic [3:0]           w_ff, w_in;
   logic [31:0]          raw_ff, raw_in, wp_ff, wp_in, best_ff, best_in;
   logic [CACHE_BITS-1:0] ent_ff, ent_in;
   logic                 match_ff, match_in, found_ff, found_in;
   logic [INDEX_BITS-1:0] t_ff, t_in, best_t_ff, best_t_in, clr_ff, clr_in;
   logic [UW-1:0]        used_ff, used_in;
   logic [63:0]          staged_ff [0:mhkv_pkg::VALUE_WORDS-1];
   logic [63:0]          staged_in [0:mhkv_pkg::VALUE_WORDS-1];
   logic [31:0]          chain_ff [0:CH_N-1];
   logic [31:0]          chain_in [0:CH_N-1];

   // RAM controls
   logic                  idx_we, idx_re, key_we, key_re, val_we, val_re;
   logic [INDEX_BITS-1:0] idx_wa, idx_ra;
   logic [31:0]           idx_wd, idx_rd;
   logic [KA_W-1:0]       key_wa, key_ra;
   logic [63:0]           key_wd, key_rd, val_wd, val_rd;
   logic [VA_W-1:0]       val_wa, val_ra;

   logic        req_xfer, out_free, stale_rd, key_eq, seen, is_find, m_next;
   logic [63:0] key_i, key_j;
   logic [VA_W-1:0] val_base_ent, val_base_raw;
   logic [UW:0] used_next;

   function automatic logic [63:0] key_word(logic [1:0] sel);
      return mhkv_pkg::key_word(req_ff, sel);
   endfunction

   assign req_stall = (state_ff != mhkv_pkg::S_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   assign key_i    = mhkv_pkg::key_word(req_ff, i_ff);
   assign key_j    = mhkv_pkg::key_word(req_ff, j_ff);
   assign stale_rd = mhkv_pkg::is_stale(wp_ff, idx_rd, CACHE_SIZE);
   assign key_eq   = (key_rd == key_j);
   assign m_next   = match_ff && key_eq;
   assign is_find  = (req_ff.operation == mhkv_pkg::OP_FIND);
   assign used_next = {1'b0, used_ff} + (UW+1)'(1);
   assign val_base_ent = VA_W'({ent_ff, 3'b000}) + VA_W'({ent_ff, 2'b00});
   assign val_base_raw = VA_W'({raw_ff[CACHE_BITS-1:0], 3'b000})
                       + VA_W'({raw_ff[CACHE_BITS-1:0], 2'b00});

   // check a candidate against positions already in the chain
   always_comb begin
      seen = 1'b0;
      for (int k = 0; k < CH_N; k++) begin
         if (((UW+1)'(k) < {1'b0, used_ff}) && (chain_ff[k] == idx_rd)) begin
            seen = 1'b1;
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mhkv_pkg::S_CLEAR: begin
            if (&clr_ff) state_in = mhkv_pkg::S_IDLE;
         end
         mhkv_pkg::S_IDLE: begin
            if (req_xfer) begin
               if (req_payload.operation == mhkv_pkg::OP_STAGE) begin
                  state_in = mhkv_pkg::S_REPLY;
               end else begin
                  state_in = mhkv_pkg::S_PR_RD;
               end
            end
         end
         mhkv_pkg::S_PR_RD: state_in = mhkv_pkg::S_PR_CHK;
         mhkv_pkg::S_PR_CHK: begin
            if (!stale_rd) begin
               state_in = mhkv_pkg::S_KC_RD;
            end else if (!is_find) begin
               state_in = mhkv_pkg::S_WR;
            end else if (i_ff == 2'd3) begin
               state_in = mhkv_pkg::S_REPLY;
            end else begin
               state_in = mhkv_pkg::S_PR_RD;
            end
         end
         mhkv_pkg::S_KC_RD: state_in = mhkv_pkg::S_KC_CHK;
         mhkv_pkg::S_KC_CHK: begin
            if (j_ff != 2'd3) begin
               state_in = mhkv_pkg::S_KC_RD;
            end else if (m_next) begin
               priority case (req_ff.operation)
                  mhkv_pkg::OP_FIND:   state_in = mhkv_pkg::S_FD_RD;
                  mhkv_pkg::OP_UPDATE: state_in = mhkv_pkg::S_WR;
                  default:             state_in = mhkv_pkg::S_REPLY;
               endcase
            end else if (i_ff != 2'd3) begin
               state_in = mhkv_pkg::S_PR_RD;
            end else if (is_find) begin
               state_in = mhkv_pkg::S_REPLY;
            end else begin
               state_in = mhkv_pkg::S_WR;
            end
         end
         mhkv_pkg::S_WR: begin
            if (w_ff == 4'(mhkv_pkg::VALUE_WORDS - 1)) begin
               state_in = (after_ff == mhkv_pkg::AW_CHAIN) ? mhkv_pkg::S_CH_STEP
                                                          : mhkv_pkg::S_REPLY;
            end
         end
         mhkv_pkg::S_FD_RD: state_in = mhkv_pkg::S_FD_OUT;
         mhkv_pkg::S_FD_OUT: begin
            if (out_free) begin
               state_in = (w_ff == 4'(mhkv_pkg::VALUE_WORDS - 1)) ? mhkv_pkg::S_IDLE
                                                                 : mhkv_pkg::S_FD_RD;
            end
         end
         mhkv_pkg::S_CH_STEP: begin
            state_in = (used_next > (UW+1)'(MAX_CHAIN)) ? mhkv_pkg::S_REPLY
                                                       : mhkv_pkg::S_CH_KRD;
         end
         mhkv_pkg::S_CH_KRD: state_in = mhkv_pkg::S_CH_IRD;
         mhkv_pkg::S_CH_IRD: state_in = mhkv_pkg::S_CH_CHK;
         mhkv_pkg::S_CH_CHK: begin
            if (stale_rd) begin
               state_in = mhkv_pkg::S_REPLY;
            end else if (j_ff == 2'd3) begin
               state_in = mhkv_pkg::S_CH_END;
            end else begin
               state_in = mhkv_pkg::S_CH_KRD;
            end
         end
         mhkv_pkg::S_CH_END: begin
            state_in = found_ff ? mhkv_pkg::S_CH_STEP : mhkv_pkg::S_REPLY;
         end
         mhkv_pkg::S_REPLY: begin
            if (out_free) state_in = mhkv_pkg::S_IDLE;
         end
         default: state_in = mhkv_pkg::S_IDLE;
      endcase
   end

   // datapath and RAM controls
   always_comb begin
      req_in    = req_ff;
      rsp_in    = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      status_in = status_ff;
      after_in  = after_ff;
      i_in = i_ff; j_in = j_ff; w_in = w_ff;
      raw_in = raw_ff; wp_in = wp_ff; best_in = best_ff; ent_in = ent_ff;
      match_in = match_ff; found_in = found_ff;
      t_in = t_ff; best_t_in = best_t_ff; clr_in = clr_ff; used_in = used_ff;
      staged_in = staged_ff;
      chain_in  = chain_ff;
      idx_we = 1'b0; idx_wa = t_ff; idx_wd = raw_ff;
      idx_re = 1'b0; idx_ra = key_i[INDEX_BITS-1:0];
      key_we = 1'b0; key_wa = {ent_ff, w_ff[1:0]}; key_wd = key_word(w_ff[1:0]);
      key_re = 1'b0; key_ra = {raw_ff[CACHE_BITS-1:0], j_ff};
      val_we = 1'b0; val_wa = val_base_ent + VA_W'(w_ff);
      val_wd = ((w_ff < 4'(mhkv_pkg::SHORT_WORDS)) || req_ff.leaf_entry)
               ? staged_ff[w_ff] : 64'd0;
      val_re = 1'b0; val_ra = val_base_raw + VA_W'(w_ff);

      unique case (state_ff)
         mhkv_pkg::S_CLEAR: begin
            // sweep the index table to its stale reset value
            idx_we = 1'b1; idx_wa = clr_ff; idx_wd = IDX_RESET;
            clr_in = clr_ff + INDEX_BITS'(1);
         end
         mhkv_pkg::S_IDLE: begin
            if (req_xfer) begin
               req_in = req_payload;
               i_in = 2'd0; j_in = 2'd0; match_in = 1'b1;
               if (req_payload.operation == mhkv_pkg::OP_STAGE) begin
                  status_in = mhkv_pkg::ST_STAGED;
                  if (req_payload.value_slot < 4'(mhkv_pkg::VALUE_WORDS)) begin
                     staged_in[req_payload.value_slot] = req_payload.value_word;
                  end
               end
            end
         end
         mhkv_pkg::S_PR_RD: begin
            idx_re = 1'b1;
         end
         mhkv_pkg::S_PR_CHK: begin
            raw_in = idx_rd; j_in = 2'd0; match_in = 1'b1; w_in = 4'd0;
            if (stale_rd) begin
               if (!is_find) begin
                  // claim the stale slot for a new entry at the pointer
                  idx_we = 1'b1; idx_wa = key_i[INDEX_BITS-1:0]; idx_wd = wp_ff;
                  ent_in = wp_ff[CACHE_BITS-1:0];
                  wp_in  = wp_ff + 32'd1;
                  after_in = mhkv_pkg::AW_NEW;
               end else begin
                  status_in = mhkv_pkg::ST_MISS;
                  i_in = i_ff + 2'd1;
               end
            end
         end
         mhkv_pkg::S_KC_RD: begin
            key_re = 1'b1;
         end
         mhkv_pkg::S_KC_CHK: begin
            match_in = m_next; j_in = j_ff + 2'd1; w_in = 4'd0;
            if (j_ff == 2'd3) begin
               if (m_next) begin
                  ent_in = raw_ff[CACHE_BITS-1:0];
                  after_in = mhkv_pkg::AW_UPD;
                  status_in = mhkv_pkg::ST_KEPT;
               end else if (i_ff != 2'd3) begin
                  i_in = i_ff + 2'd1;
               end else if (is_find) begin
                  status_in = mhkv_pkg::ST_MISS;
               end else begin
                  // forced insertion at the pointer, then displace
                  ent_in = wp_ff[CACHE_BITS-1:0];
                  chain_in[0] = wp_ff;
                  wp_in = wp_ff + 32'd1;
                  used_in = '0;
                  after_in = mhkv_pkg::AW_CHAIN;
               end
            end
         end
         mhkv_pkg::S_WR: begin
            val_we = 1'b1;
            key_we = (w_ff < 4'(mhkv_pkg::KEY_WORDS));
            w_in = w_ff + 4'd1;
            status_in = (after_ff == mhkv_pkg::AW_NEW) ? mhkv_pkg::ST_NEW
                                                       : mhkv_pkg::ST_UPDATED;
         end
         mhkv_pkg::S_FD_RD: begin
            val_re = 1'b1;
         end
         mhkv_pkg::S_FD_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in.status    = mhkv_pkg::ST_HIT;
               rsp_in.word_slot = w_ff;
               rsp_in.data_word = val_rd;
               rsp_in.last      = (w_ff == 4'(mhkv_pkg::VALUE_WORDS - 1));
               w_in = w_ff + 4'd1;
            end
         end
         mhkv_pkg::S_CH_STEP: begin
            raw_in = chain_ff[used_ff];
            used_in = used_next[UW-1:0];
            j_in = 2'd0; found_in = 1'b0; best_in = 32'hFFFF_FFFF;
            status_in = mhkv_pkg::ST_FAILED;
         end
         mhkv_pkg::S_CH_KRD: begin
            key_re = 1'b1;
         end
         mhkv_pkg::S_CH_IRD: begin
            t_in = key_rd[INDEX_BITS-1:0];
            idx_re = 1'b1; idx_ra = key_rd[INDEX_BITS-1:0];
         end
         mhkv_pkg::S_CH_CHK: begin
            j_in = j_ff + 2'd1;
            if (stale_rd) begin
               idx_we = 1'b1;
               status_in = mhkv_pkg::ST_FORCED;
            end else if (!seen && (idx_rd < best_ff)) begin
               best_in = idx_rd; best_t_in = t_ff; found_in = 1'b1;
            end
         end
         mhkv_pkg::S_CH_END: begin
            if (found_ff) begin
               // displace the oldest slot and place its position next
               idx_we = 1'b1; idx_wa = best_t_ff;
               chain_in[used_ff] = best_ff;
            end
         end
         mhkv_pkg::S_REPLY: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in.status    = status_ff;
               rsp_in.word_slot = 4'd0;
               rsp_in.data_word = 64'd0;
               rsp_in.last      = 1'b1;
            end
         end
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mhkv_pkg::S_CLEAR;
         rsp_valid_ff <= 1'b0;
         wp_ff        <= 32'd0;
         clr_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         wp_ff        <= wp_in;
         clr_ff       <= clr_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_ff <= req_in; rsp_ff <= rsp_in; status_ff <= status_in;
      after_ff <= after_in; i_ff <= i_in; j_ff <= j_in; w_ff <= w_in;
      raw_ff <= raw_in; best_ff <= best_in; ent_ff <= ent_in;
      match_ff <= match_in; found_ff <= found_in; t_ff <= t_in;
      best_t_ff <= best_t_in; used_ff <= used_in;
      staged_ff <= staged_in; chain_ff <= chain_in;
   end

   mhkv_ram #(.WIDTH(32), .ADDR_W(INDEX_BITS), .DEPTH(64'd1 << INDEX_BITS)) u_idx_ram (
      .clock(clock), .wr_en(idx_we), .wr_addr(idx_wa), .wr_data(idx_wd),
      .rd_en(idx_re), .rd_addr(idx_ra), .rd_data(idx_rd)
   );

   mhkv_ram #(.WIDTH(64), .ADDR_W(KA_W), .DEPTH(64'd4 << CACHE_BITS)) u_key_ram (
      .clock(clock), .wr_en(key_we), .wr_addr(key_wa), .wr_data(key_wd),
      .rd_en(key_re), .rd_addr(key_ra), .rd_data(key_rd)
   );

   mhkv_ram #(.WIDTH(64), .ADDR_W(VA_W), .DEPTH(64'd12 << CACHE_BITS)) u_val_ram (
      .clock(clock), .wr_en(val_we), .wr_addr(val_wa), .wr_data(val_wd),
      .rd_en(val_re), .rd_addr(val_ra), .rd_data(val_rd)
   );

endmodule

[hw/rtl/mhkv_checker.sv]
// ----------------------------------------------------------------------------
// mhkv_checker: port-level checks for the multi-hash key/value cache
// Watches the request and result channels and flags illegal behavior.
// ----------------------------------------------------------------------------
module mhkv_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input mhkv_pkg::req_type req_payload,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input mhkv_pkg::rsp_type rsp_payload
);

   // reset drops results and holds off requests during the clearing pass
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_stall)
      else $error("result or request transfer right after reset");

   // a stalled request holds until transferred
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_payload))
      else $error("stalled request changed");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result changed");

   // hit words close on the twelfth word only
   a_hit_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.status == mhkv_pkg::ST_HIT)
      |-> rsp_payload.last == (rsp_payload.word_slot == 4'd11))
      else $error("hit word with wrong last flag");

   // every other status is a single zero-data result
   a_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.status != mhkv_pkg::ST_HIT)
      |-> rsp_payload.last && (rsp_payload.data_word == 64'd0)
          && (rsp_payload.word_slot == 4'd0))
      else $error("non-hit result not a single empty transfer");

endmodule

bind multi_hash_key_value_cache mhkv_checker u_mhkv_checker (
   .clock(clock), .reset(reset),
   .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload)
);
